>>> rtl/bpa_pkg.sv
// Shared types, field widths and codes of the bitmap block pool allocator.
package bpa_pkg;

    localparam int PAGE_W    = 4;
    localparam int OFF_W     = 12;
    localparam int BLK_W     = 6;
    localparam int SIZE_W    = 11;
    localparam int BPP_W     = 7;
    localparam int CFG_AW    = 1;
    localparam int CFG_DW    = 11;

    // Effective block size is at most 2048 bytes and always a multiple of 8.
    localparam int ESIZE_W   = 12;
    localparam int ALIGN_W   = 3;

    // Offset and size are divided in units of 8 bytes.
    localparam int DIV_W     = OFF_W - ALIGN_W;
    localparam int DVS_W     = ESIZE_W - ALIGN_W;
    localparam int DIV_STEP  = 2;
    localparam int DIV_CYC   = (DIV_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_PAD   = DIV_CYC * DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_CYC + 1);

    localparam logic [CFG_AW-1:0] CFG_ALLOC_SIZE = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_BLOCKS     = 1'b1;

    localparam logic [SIZE_W-1:0] ALLOC_SIZE_RST = 11'd64;
    localparam logic [BPP_W-1:0]  BPP_RST        = 7'd63;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_OOM         = 2'd1,
        ST_NOT_IN_POOL = 2'd2
    } t_status;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_kind;

    typedef struct packed {
        t_req_kind          req_type;
        logic [PAGE_W-1:0]  free_page;
        logic [OFF_W-1:0]   free_offset;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [PAGE_W-1:0]  page_index;
        logic [BLK_W-1:0]   block_index;
        logic [OFF_W-1:0]   byte_offset;
        logic               page_released;
    } t_rsp;

endpackage

>>> rtl/bitmap_block_pool_allocator_top.sv
// Top level of the bitmap block pool allocator: page bitmap memory, scan and free control.
//
//  channel   direction  signals                             transfer
//  request   in         start, i_req (t_req), busy          start && !busy
//  result    out        o_done, o_rsp (t_rsp)               one cycle while o_done is high
//  config    in         i_cfg_we, i_cfg_idx, i_cfg_wdata    every edge with i_cfg_we high
//
//  An allocation takes the lowest free block of the first open page that has one, else
//  opens a fresh page if any is closed. The scan reads one bitmap word per cycle from the
//  page memory. A free waits on the divider (two quotient bits per cycle); a rejected
//  free does not. A new request is taken in the cycle its predecessor's result shows.
//  After reset page 0 reads as its reset bitmap until first written; no clearing pass is run.
//  The result port has no back pressure.
module bitmap_block_pool_allocator_top #(
    parameter int NUM_PAGES  = 16,
    parameter int BLOCKS_MAX = 64,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  bpa_pkg::t_req                 i_req,
    output logic                          busy,
    output logic                          o_done,
    output bpa_pkg::t_rsp                 o_rsp,
    input  logic                          i_cfg_we,
    input  logic [bpa_pkg::CFG_AW-1:0]    i_cfg_idx,
    input  logic [bpa_pkg::CFG_DW-1:0]    i_cfg_wdata
);

    localparam int PG_W     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CNT_W    = $clog2(NUM_PAGES + 1);
    localparam int SIZE_LO  = PAGE_BYTES / BLOCKS_MAX;
    localparam int OFFCHK_W = $clog2(PAGE_BYTES + 1) + bpa_pkg::OFF_W;
    localparam int PROD_W   = bpa_pkg::BLK_W + bpa_pkg::ESIZE_W;
    localparam int RST_BLKS = (BLOCKS_MAX < int'(bpa_pkg::BPP_RST)) ? BLOCKS_MAX
                                                                    : int'(bpa_pkg::BPP_RST);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN     = 6'b000010,
        S_ALLOC_WR = 6'b000100,
        S_NEW_PG   = 6'b001000,
        S_FREE_DIV = 6'b010000,
        S_OUT      = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [bpa_pkg::SIZE_W-1:0]  r_alloc_size;
    logic [bpa_pkg::BPP_W-1:0]   r_bpp;

    logic [bpa_pkg::ESIZE_W-1:0] w_size_lo;
    logic [bpa_pkg::ESIZE_W-1:0] w_size_m1;
    logic [bpa_pkg::ESIZE_W-1:0] w_size;
    logic [bpa_pkg::BPP_W-1:0]   w_nblk;
    logic [BLOCKS_MAX-1:0]       w_hm;

    logic [bpa_pkg::ESIZE_W-1:0] r_size;
    logic [bpa_pkg::BPP_W-1:0]   r_nblk;
    logic [BLOCKS_MAX-1:0]       r_hm;

    logic [BLOCKS_MAX-1:0]       r_mem [NUM_PAGES];
    logic [BLOCKS_MAX-1:0]       r_mem_q;
    logic [PG_W-1:0]             r_rd_pg;
    logic                        r_pg0_vld;
    logic                        w_rd_en;
    logic [PG_W-1:0]             w_rd_addr;
    logic                        w_wr_en;
    logic [PG_W-1:0]             w_wr_addr;
    logic [BLOCKS_MAX-1:0]       w_wr_data;
    logic [BLOCKS_MAX-1:0]       w_pg0_rst;
    logic [BLOCKS_MAX-1:0]       w_rd_word;

    logic [NUM_PAGES-1:0]        r_active;

    logic [CNT_W-1:0]            r_scan_nxt;
    logic                        r_new_found;
    logic [PG_W-1:0]             r_new_pg;
    logic [BLOCKS_MAX-1:0]       r_word;
    logic [PG_W-1:0]             r_pg;

    bpa_pkg::t_status            r_status;
    logic [bpa_pkg::PAGE_W-1:0]  r_out_pg;
    logic [bpa_pkg::BLK_W-1:0]   r_blk;
    logic                        r_rel;
    logic                        r_done;
    bpa_pkg::t_rsp               r_rsp;

    logic                        w_accept;
    logic                        w_is_alloc;
    logic [8:0]                  w_fp_ext;
    logic [PG_W-1:0]             w_free_addr;
    logic                        w_free_ok;

    logic                        w_act_rd;
    logic [BLOCKS_MAX-1:0]       w_avail_rd;
    logic                        w_hit;
    logic                        w_last;
    logic                        w_scan_more;

    logic [BLOCKS_MAX-1:0]       w_avail;
    logic [BLOCKS_MAX-1:0]       w_low;
    logic [bpa_pkg::BLK_W-1:0]   w_low_idx;

    logic                        w_div_start;
    logic                        w_div_done;
    logic [bpa_pkg::DIV_W-1:0]   w_div_quot;
    logic                        w_idx_ok;
    logic [BLOCKS_MAX-1:0]       w_clr;
    logic [BLOCKS_MAX-1:0]       w_freed;
    logic                        w_rel;

    logic [PROD_W-1:0]           w_prod;

    function automatic logic [bpa_pkg::PAGE_W-1:0] pg_out(input logic [PG_W-1:0] p);
        logic [8:0] e;
        e = 9'(p);
        return e[bpa_pkg::PAGE_W-1:0];
    endfunction

    // Effective block size and usable block mask, both taken from the live registers.
    always_comb begin
        w_size_lo = (12'(r_alloc_size) < 12'(SIZE_LO)) ? 12'(SIZE_LO) : 12'(r_alloc_size);
        w_size_m1 = w_size_lo - 12'd1;
        w_size    = (w_size_m1 | 12'd7) + 12'd1;
        if (r_bpp == '0) begin
            w_nblk = bpa_pkg::BPP_W'(1);
        end else if (r_bpp > bpa_pkg::BPP_W'(BLOCKS_MAX)) begin
            w_nblk = bpa_pkg::BPP_W'(BLOCKS_MAX);
        end else begin
            w_nblk = r_bpp;
        end
        for (int i = 0; i < BLOCKS_MAX; i++) begin
            w_hm[i]      = (bpa_pkg::BPP_W'(i) >= w_nblk);
            w_pg0_rst[i] = (i >= RST_BLKS);
        end
    end

    // Page 0 keeps its reset bitmap until its first write.
    assign w_rd_word = ((r_rd_pg == '0) && !r_pg0_vld) ? w_pg0_rst : r_mem_q;

    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    assign w_is_alloc  = (i_req.req_type == bpa_pkg::REQ_ALLOC);
    assign w_fp_ext    = 9'(i_req.free_page);
    assign w_free_addr = w_fp_ext[PG_W-1:0];
    assign w_free_ok   = (w_fp_ext < 9'(NUM_PAGES)) && r_active[w_free_addr]
                      && (OFFCHK_W'(i_req.free_offset) < OFFCHK_W'(PAGE_BYTES));

    assign w_act_rd    = r_active[r_rd_pg];
    assign w_avail_rd  = ~(w_rd_word | r_hm);
    assign w_hit       = w_act_rd && (w_avail_rd != '0);
    assign w_last      = (r_rd_pg == PG_W'(NUM_PAGES - 1));
    assign w_scan_more = (r_scan_nxt < CNT_W'(NUM_PAGES));

    // Lowest free block: isolate the lowest set bit, then encode it.
    assign w_avail = ~(r_word | r_hm);
    assign w_low   = w_avail & (~w_avail + BLOCKS_MAX'(1));
    always_comb begin
        w_low_idx = '0;
        for (int i = 0; i < BLOCKS_MAX; i++) begin
            if (w_low[i]) begin
                w_low_idx = w_low_idx | bpa_pkg::BLK_W'(i);
            end
        end
    end

    assign w_idx_ok = (w_div_quot < bpa_pkg::DIV_W'(r_nblk));
    always_comb begin
        for (int i = 0; i < BLOCKS_MAX; i++) begin
            w_clr[i] = (bpa_pkg::BLK_W'(i) == w_div_quot[bpa_pkg::BLK_W-1:0]);
        end
    end
    assign w_freed = w_rd_word & ~w_clr;
    assign w_rel   = (r_pg != '0) && ((w_freed & ~r_hm) == '0);

    assign w_prod = PROD_W'(r_blk) * PROD_W'(r_size);

    assign w_div_start = w_accept && !w_is_alloc && w_free_ok;

    bpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_req.free_offset[bpa_pkg::OFF_W-1:bpa_pkg::ALIGN_W]),
        .i_divisor  (w_size[bpa_pkg::ESIZE_W-1:bpa_pkg::ALIGN_W]),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // Next state and memory port control.
    always_comb begin
        n_state   = r_state;
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_pg;
        w_wr_data = w_freed;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_is_alloc) begin
                        w_rd_en = 1'b1;
                        n_state = S_SCAN;
                    end else if (w_free_ok) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_free_addr;
                        n_state   = S_FREE_DIV;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SCAN: begin
                w_rd_en   = w_scan_more;
                w_rd_addr = r_scan_nxt[PG_W-1:0];
                if (w_hit) begin
                    n_state = S_ALLOC_WR;
                end else if (w_last) begin
                    n_state = (r_new_found || !w_act_rd) ? S_NEW_PG : S_OUT;
                end
            end
            S_ALLOC_WR: begin
                w_wr_en   = 1'b1;
                w_wr_data = r_word | w_low;
                n_state   = S_OUT;
            end
            S_NEW_PG: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_new_pg;
                w_wr_data = r_hm | BLOCKS_MAX'(1);
                n_state   = S_OUT;
            end
            S_FREE_DIV: begin
                if (w_div_done) begin
                    w_wr_en = w_idx_ok;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_mem_q <= r_mem[w_rd_addr];
            r_rd_pg <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_alloc_size <= bpa_pkg::ALLOC_SIZE_RST;
            r_bpp        <= bpa_pkg::BPP_RST;
            r_active     <= NUM_PAGES'(1);
            r_pg0_vld    <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_OUT);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bpa_pkg::CFG_ALLOC_SIZE: r_alloc_size <= i_cfg_wdata;
                    bpa_pkg::CFG_BLOCKS:     r_bpp <= i_cfg_wdata[bpa_pkg::BPP_W-1:0];
                    default: ;
                endcase
            end
            if (w_wr_en && (w_wr_addr == '0)) begin
                r_pg0_vld <= 1'b1;
            end
            if (r_state == S_NEW_PG) begin
                r_active[r_new_pg] <= 1'b1;
            end
            if ((r_state == S_FREE_DIV) && w_div_done && w_idx_ok && w_rel) begin
                r_active[r_pg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_size      <= w_size;
                    r_nblk      <= w_nblk;
                    r_hm        <= w_hm;
                    r_scan_nxt  <= CNT_W'(1);
                    r_new_found <= 1'b0;
                    r_pg        <= w_free_addr;
                    r_out_pg    <= i_req.free_page;
                    r_status    <= bpa_pkg::ST_NOT_IN_POOL;
                    r_blk       <= '0;
                    r_rel       <= 1'b0;
                end
            end
            S_SCAN: begin
                if (w_scan_more) begin
                    r_scan_nxt <= r_scan_nxt + CNT_W'(1);
                end
                if (!w_act_rd && !r_new_found) begin
                    r_new_found <= 1'b1;
                    r_new_pg    <= r_rd_pg;
                end
                if (w_hit) begin
                    r_word <= w_rd_word;
                    r_pg   <= r_rd_pg;
                end else if (w_last) begin
                    r_status <= bpa_pkg::ST_OOM;
                    r_out_pg <= '0;
                end
            end
            S_ALLOC_WR: begin
                r_status <= bpa_pkg::ST_OK;
                r_out_pg <= pg_out(r_pg);
                r_blk    <= w_low_idx;
            end
            S_NEW_PG: begin
                r_status <= bpa_pkg::ST_OK;
                r_out_pg <= pg_out(r_new_pg);
                r_blk    <= '0;
            end
            S_FREE_DIV: begin
                if (w_div_done && w_idx_ok) begin
                    r_status <= bpa_pkg::ST_OK;
                    r_blk    <= w_div_quot[bpa_pkg::BLK_W-1:0];
                    r_rel    <= w_rel;
                end
            end
            S_OUT: begin
                r_rsp <= '{status:        r_status,
                           page_index:    r_out_pg,
                           block_index:   r_blk,
                           byte_offset:   w_prod[bpa_pkg::OFF_W-1:0],
                           page_released: r_rel};
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef SYNTHESIS
    a_pg0_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active[0])
        else $error("page 0 became inactive");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted transaction did not raise busy");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr_en && w_rd_en && (w_wr_addr == w_rd_addr)))
        else $error("bitmap read and write to the same page in one cycle");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_FREE_DIV))
        else $error("divider finished outside a free");

    a_oom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == bpa_pkg::ST_OOM)) |->
        ((o_rsp.page_index == '0) && (o_rsp.block_index == '0)
         && (o_rsp.byte_offset == '0) && !o_rsp.page_released))
        else $error("out of memory result carries nonzero fields");
`endif

endmodule

>>> rtl/bpa_div.sv
// Radix-4 restoring divider that turns a freed offset into a block number.
module bpa_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bpa_pkg::DIV_W-1:0]   i_dividend,
    input  logic [bpa_pkg::DVS_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [bpa_pkg::DIV_W-1:0]   o_quot
);

    logic [bpa_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_done;
    logic [bpa_pkg::DVS_W-1:0]     r_dvs;
    logic [bpa_pkg::DVS_W-1:0]     r_rem;
    logic [bpa_pkg::DVS_W-1:0]     n_rem;
    logic [bpa_pkg::DIV_PAD-1:0]   r_sh;
    logic [bpa_pkg::DIV_PAD-1:0]   n_sh;
    logic [bpa_pkg::DVS_W:0]       w_trial;

    // Dividend bits shift out at the top while quotient bits shift in at the bottom.
    always_comb begin
        n_rem   = r_rem;
        n_sh    = r_sh;
        w_trial = '0;
        for (int k = 0; k < bpa_pkg::DIV_STEP; k++) begin
            w_trial = {n_rem, n_sh[bpa_pkg::DIV_PAD-1]};
            n_sh    = {n_sh[bpa_pkg::DIV_PAD-2:0], 1'b0};
            if (w_trial >= {1'b0, r_dvs}) begin
                w_trial = w_trial - {1'b0, r_dvs};
                n_sh[0] = 1'b1;
            end
            n_rem = w_trial[bpa_pkg::DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= bpa_pkg::DIV_CNT_W'(bpa_pkg::DIV_CYC);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - bpa_pkg::DIV_CNT_W'(1);
                r_done <= (r_cnt == bpa_pkg::DIV_CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_sh  <= bpa_pkg::DIV_PAD'(i_dividend);
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_sh  <= n_sh;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sh[bpa_pkg::DIV_W-1:0];

endmodule

>>> test/bitmap_block_pool_allocator_top_tb.sv
// Self-checking testbench for the bitmap block pool allocator top level.
`timescale 1ns / 100ps

module bitmap_block_pool_allocator_top_tb;

    localparam int N_PAGES     = 16;
    localparam int MAX_BLOCKS  = 64;
    localparam int PAGE_SPAN   = 4096;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 150;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 300000;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       start       = 1'b0;
    bpa_pkg::t_req              i_req       = '0;
    logic                       busy;
    logic                       o_done;
    bpa_pkg::t_rsp              o_rsp;
    logic                       i_cfg_we    = 1'b0;
    logic [bpa_pkg::CFG_AW-1:0] i_cfg_idx   = bpa_pkg::CFG_ALLOC_SIZE;
    logic [bpa_pkg::CFG_DW-1:0] i_cfg_wdata = '0;

    // Shadow of the allocator state and its registers.
    logic [63:0]                page_map [N_PAGES];
    bit                         page_on  [N_PAGES];
    logic [bpa_pkg::SIZE_W-1:0] cfg_size;
    logic [bpa_pkg::BPP_W-1:0]  cfg_bpp;

    bpa_pkg::t_req              req_q [$];
    bpa_pkg::t_rsp              rsp_q [$];
    bpa_pkg::t_rsp              want_rsp;
    bit                         idle_en = 1'b1;
    int unsigned                err_cnt = 0;
    int unsigned                cycle_cnt = 0;
    int unsigned                n_txn = 0;
    int unsigned                n_alloc = 0;
    int unsigned                n_oom = 0;
    int unsigned                n_free = 0;
    int unsigned                n_reject = 0;
    int unsigned                n_release = 0;
    int unsigned                n_settings = 1;

    bitmap_block_pool_allocator_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Sizes below a 64th of the page are raised, then rounded up to 8 bytes.
    function automatic int unsigned block_bytes();
        int unsigned s;
        s = 32'(cfg_size);
        if (s < PAGE_SPAN / MAX_BLOCKS) s = PAGE_SPAN / MAX_BLOCKS;
        return ((s - 1) | 7) + 1;
    endfunction

    function automatic int unsigned block_count();
        int unsigned n;
        n = 32'(cfg_bpp);
        if (n < 1) n = 1;
        if (n > MAX_BLOCKS) n = MAX_BLOCKS;
        return n;
    endfunction

    // Blocks at or above the usable count always look taken.
    function automatic logic [63:0] unusable_mask();
        int unsigned n;
        n = block_count();
        if (n >= 64) return 64'd0;
        return ~64'd0 << n;
    endfunction

    // Applies one accepted request to the shadow state and returns the response it earns.
    function automatic bpa_pkg::t_rsp pool_response(bpa_pkg::t_req r);
        bpa_pkg::t_rsp rsp;
        logic [63:0]   hm;
        logic [63:0]   avail;
        logic [31:0]   prod;
        int unsigned   size;
        int unsigned   idx;
        int unsigned   pg;
        rsp = '0;
        rsp.status = bpa_pkg::ST_OK;
        hm = unusable_mask();
        size = block_bytes();
        n_txn++;
        if (r.req_type == bpa_pkg::REQ_ALLOC) begin
            n_alloc++;
            for (int p = 0; p < N_PAGES; p++) begin
                if (page_on[p]) begin
                    avail = ~(page_map[p] | hm);
                    if (avail != 64'd0) begin
                        for (int b = 0; b < 64; b++) begin
                            if (avail[b]) begin
                                page_map[p][b] = 1'b1;
                                prod = b * size;
                                rsp.page_index = bpa_pkg::PAGE_W'(p);
                                rsp.block_index = bpa_pkg::BLK_W'(b);
                                rsp.byte_offset = prod[bpa_pkg::OFF_W-1:0];
                                return rsp;
                            end
                        end
                    end
                end
            end
            // No room in any open page: open the lowest closed one.
            for (int p = 0; p < N_PAGES; p++) begin
                if (!page_on[p]) begin
                    page_on[p] = 1'b1;
                    page_map[p] = hm | 64'd1;
                    rsp.page_index = bpa_pkg::PAGE_W'(p);
                    return rsp;
                end
            end
            n_oom++;
            rsp.status = bpa_pkg::ST_OOM;
            return rsp;
        end
        n_free++;
        pg = 32'(r.free_page);
        idx = 32'(r.free_offset) / size;
        rsp.page_index = r.free_page;
        if (!page_on[pg] || idx >= block_count()) begin
            n_reject++;
            rsp.status = bpa_pkg::ST_NOT_IN_POOL;
            return rsp;
        end
        page_map[pg][idx] = 1'b0;
        if (pg != 0 && (page_map[pg] & ~hm) == 64'd0) begin
            page_on[pg] = 1'b0;
            rsp.page_released = 1'b1;
            n_release++;
        end
        prod = idx * size;
        rsp.block_index = bpa_pkg::BLK_W'(idx);
        rsp.byte_offset = prod[bpa_pkg::OFF_W-1:0];
        return rsp;
    endfunction

    // Allocations carry random junk in the fields they do not use.
    function automatic bpa_pkg::t_req alloc_req();
        bpa_pkg::t_req r;
        r.req_type = bpa_pkg::REQ_ALLOC;
        r.free_page = bpa_pkg::PAGE_W'($urandom);
        r.free_offset = bpa_pkg::OFF_W'($urandom);
        return r;
    endfunction

    function automatic bpa_pkg::t_req free_req(int unsigned pg, int unsigned off);
        bpa_pkg::t_req r;
        r.req_type = bpa_pkg::REQ_FREE;
        r.free_page = bpa_pkg::PAGE_W'(pg);
        r.free_offset = bpa_pkg::OFF_W'(off);
        return r;
    endfunction

    // Mostly legal traffic: allocations and frees of blocks that are in use,
    // with a tenth of raw random frees mixed in.
    function automatic bpa_pkg::t_req random_req(int unsigned alloc_pct);
        int unsigned roll;
        int unsigned size;
        int unsigned nblk;
        int unsigned p0;
        int unsigned b0;
        int unsigned pg;
        int unsigned blk;
        int unsigned base;
        int unsigned span;
        roll = $urandom_range(99);
        if (roll < 10) return free_req($urandom_range(15), $urandom_range(PAGE_SPAN - 1));
        if (roll < 10 + alloc_pct * 90 / 100) return alloc_req();
        size = block_bytes();
        nblk = block_count();
        p0 = $urandom_range(N_PAGES - 1);
        b0 = $urandom_range(nblk - 1);
        for (int i = 0; i < N_PAGES; i++) begin
            pg = (p0 + i) % N_PAGES;
            if (page_on[pg]) begin
                for (int j = 0; j < nblk; j++) begin
                    blk = (b0 + j) % nblk;
                    base = blk * size;
                    if (page_map[pg][blk] && base < PAGE_SPAN) begin
                        span = size - 1;
                        if (span > PAGE_SPAN - 1 - base) span = PAGE_SPAN - 1 - base;
                        if ($urandom_range(3) == 0) span = 0;
                        return free_req(pg, base + $urandom_range(span));
                    end
                end
            end
        end
        return alloc_req();
    endfunction

    task automatic check_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, fname, want, got);
            err_cnt++;
        end
    endtask

    task automatic write_reg(logic [bpa_pkg::CFG_AW-1:0] idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val[bpa_pkg::CFG_DW-1:0];
        if (idx == bpa_pkg::CFG_ALLOC_SIZE) cfg_size = val[bpa_pkg::SIZE_W-1:0];
        else cfg_bpp = val[bpa_pkg::BPP_W-1:0];
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (req_q.size() != 0 || start || rsp_q.size() != 0);
    endtask

    // Request driver: predicts each transaction as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) rsp_q.push_back(pool_response(i_req));
            if (start && busy) begin
                // Hold the pending request until the block takes it.
            end else if (req_q.size() != 0 && !(idle_en && $urandom_range(99) < 16)) begin
                start <= 1'b1;
                i_req <= req_q.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Response monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (rsp_q.size() == 0) begin
                $display("%0t: unexpected response, expected none, got %p", $realtime, o_rsp);
                err_cnt++;
            end else begin
                want_rsp = rsp_q.pop_front();
                check_field("status", 32'(want_rsp.status), 32'(o_rsp.status));
                check_field("page_index", 32'(want_rsp.page_index), 32'(o_rsp.page_index));
                check_field("block_index", 32'(want_rsp.block_index),
                            32'(o_rsp.block_index));
                check_field("byte_offset", 32'(want_rsp.byte_offset),
                            32'(o_rsp.byte_offset));
                check_field("page_released", 32'(want_rsp.page_released),
                            32'(o_rsp.page_released));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d responses outstanding", $realtime, rsp_q.size());
            $display("bitmap_block_pool_allocator_top verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned sz;
        int unsigned bpp;
        cfg_size = bpa_pkg::ALLOC_SIZE_RST;
        cfg_bpp = bpa_pkg::BPP_RST;
        for (int p = 0; p < N_PAGES; p++) begin
            page_map[p] = '1;
            page_on[p] = 1'b0;
        end
        page_map[0] = unusable_mask();
        page_on[0] = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: 64-byte blocks, 63 usable per page.
        @(negedge i_clk);
        req_q.push_back(alloc_req());
        req_q.push_back(alloc_req());
        req_q.push_back(free_req(0, 64));
        req_q.push_back(free_req(0, 64));      // double free reads as ok
        req_q.push_back(free_req(0, 4095));    // block past the usable count
        req_q.push_back(free_req(5, 0));       // page never opened
        req_q.push_back(free_req(0, 100));     // offset inside a block, not at its start
        wait_drained();

        // One block per page and the smallest size: fill the pool to out of memory.
        write_reg(bpa_pkg::CFG_ALLOC_SIZE, 0);
        write_reg(bpa_pkg::CFG_BLOCKS, 0);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
        @(negedge i_clk);
        repeat (16) req_q.push_back(alloc_req());
        req_q.push_back(free_req(3, 0));       // empties and releases page 3
        req_q.push_back(free_req(3, 0));       // page 3 is closed again
        req_q.push_back(free_req(0, 0));       // page 0 stays open
        req_q.push_back(free_req(15, 4095));
        req_q.push_back(alloc_req());
        wait_drained();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin sz = 2047; bpp = 64; end
                1: begin sz = 64; bpp = 2; end
                2: begin sz = 1; bpp = 127; end
                3: begin sz = 640; bpp = 5; end
                4: begin sz = 2040; bpp = 64; end
                5: begin sz = 72; bpp = 3; end
                default: begin sz = $urandom_range(2047); bpp = $urandom_range(127); end
            endcase
            write_reg(bpa_pkg::CFG_ALLOC_SIZE, sz);
            write_reg(bpa_pkg::CFG_BLOCKS, bpp);
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            n_settings++;
            idle_en = (ph != 2);
            // Fill during the first half of a phase, drain during the second.
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                do @(negedge i_clk);
                while (req_q.size() != 0);
                req_q.push_back(random_req(i < PHASE_ITEMS / 2 ? 80 : 25));
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d transactions, %0d settings, %0d allocations (%0d out of memory).",
                 n_txn, n_settings, n_alloc, n_oom);
        $display("Frees: %0d, of which %0d rejected and %0d released a page.",
                 n_free, n_reject, n_release);
        if (err_cnt == 0) begin
            $display("bitmap_block_pool_allocator_top verification clean");
        end else begin
            $display("bitmap_block_pool_allocator_top verification failed");
        end
        $finish;
    end

endmodule

>>> bitmap_block_pool_allocator_top.f
rtl/bpa_pkg.sv
rtl/bpa_div.sv
rtl/bitmap_block_pool_allocator_top.sv
test/bitmap_block_pool_allocator_top_tb.sv
